[rtl/rth_pkg.sv]
// rth_pkg: shared widths, types and helpers of the RGB to HSV converter.
// Depends on nothing; every other file imports it.
package rth_pkg;

    // Width of one color component
    localparam int COMPONENT_BITS = 8;
    localparam int COMP_MAX       = (1 << COMPONENT_BITS) - 1;

    // Hue scaling: 1/64 degree units, wrapped at 360 degrees
    localparam int HUE_W      = 15;
    localparam int HUE_FRAC   = 64;
    localparam int DEG60      = 60;
    localparam int DEG120     = 120;
    localparam int DEG240     = 240;
    localparam int DEG360     = 360;
    localparam int HUE_FULL   = DEG360 * HUE_FRAC;
    localparam int HUE_GAIN2  = 2 * DEG60 * HUE_FRAC;    // doubled for rounding
    localparam int HUE_SUM_W  = HUE_W + 1;

    // Biased hue difference chroma + diff, 0 .. 2*chroma
    localparam int DP_W       = COMPONENT_BITS + 2;

    // Divider: one quotient bit per stage, both lanes share the stage count
    localparam int HUE_QW    = 13;                       // hue fraction < 2^13
    localparam int DIV_STEPS = HUE_QW;
    localparam int SAT_SHIFT = HUE_QW - COMPONENT_BITS;  // extra bits in sat lane
    localparam int REM_W     = COMPONENT_BITS + 1;       // divisor is 2*C or 2*M
    localparam int HNUM_W    = COMPONENT_BITS + 14;
    localparam int SNUM_W    = 2 * COMPONENT_BITS + 1 + SAT_SHIFT;

    typedef logic [COMPONENT_BITS-1:0] t_comp;
    typedef logic [HUE_W-1:0]          t_hue;

    // Sextant of the largest component, picks the hue offset
    typedef enum logic [1:0] {
        HB_0,
        HB_120,
        HB_240,
        HB_360
    } t_hue_base;

    // One restoring-division lane: partial remainder, divisor, and a
    // register that shifts numerator bits out and quotient bits in.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  dvs;
        logic [HUE_QW-1:0] bits;
    } t_div_lane;

    typedef struct packed {
        t_div_lane hue;
        t_div_lane sat;
        t_hue_base base;
        logic      grey;
        logic      black;
        t_comp     value;
    } t_div_slot;

    // One quotient bit
    function automatic t_div_lane div_step(input t_div_lane x);
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        t_div_lane      y;
        y     = x;
        trial = {x.rem, x.bits[HUE_QW-1]};
        diff  = trial - {1'b0, x.dvs};
        if (trial >= {1'b0, x.dvs}) begin
            y.rem  = diff[REM_W-1:0];
            y.bits = {x.bits[HUE_QW-2:0], 1'b1};
        end else begin
            y.rem  = trial[REM_W-1:0];
            y.bits = {x.bits[HUE_QW-2:0], 1'b0};
        end
        return y;
    endfunction

    // Offset base*64 - 60*64 (the fraction was biased by +chroma), mod 2^16
    function automatic logic [HUE_SUM_W-1:0] hue_offset(input t_hue_base base);
        logic [HUE_SUM_W-1:0] off;
        unique case (base)
            HB_0:    off = HUE_SUM_W'(0 - DEG60 * HUE_FRAC);
            HB_120:  off = HUE_SUM_W'((DEG120 - DEG60) * HUE_FRAC);
            HB_240:  off = HUE_SUM_W'((DEG240 - DEG60) * HUE_FRAC);
            HB_360:  off = HUE_SUM_W'((DEG360 - DEG60) * HUE_FRAC);
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

[rtl/rth_ifs.sv]
// rth_ifs: valid/ready channel interfaces for pixels in and HSV results out.
// Depends on rth_pkg.
interface rth_pix_if;
    import rth_pkg::*;
    logic  valid;
    logic  ready;
    t_comp red;
    t_comp green;
    t_comp blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
    import rth_pkg::*;
    logic  valid;
    logic  ready;
    t_hue  hue;
    t_comp saturation;
    t_comp brightness;
    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

[rtl/rth_front.sv]
// rth_front: two stages that sort the components and build both dividends.
// Depends on rth_pkg.
module rth_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rth_pkg::t_comp    i_red,
    input  rth_pkg::t_comp    i_green,
    input  rth_pkg::t_comp    i_blue,
    output logic              o_valid,
    output rth_pkg::t_div_slot o_slot
);
    import rth_pkg::*;

    // stage 1: max, min, sextant
    logic      r_s1_valid;
    t_comp     r_s1_r, r_s1_g, r_s1_b, r_s1_mx, r_s1_mn;
    t_hue_base r_s1_base;
    t_comp     n_mx, n_mn;
    t_hue_base n_base;

    // stage 2: dividends
    logic      r_s2_valid;
    t_div_slot r_s2_slot;
    t_div_slot n_slot;
    t_comp     chroma, pos, neg;
    logic [DP_W-1:0]   dp;
    logic [HNUM_W-1:0] hnum;
    logic [SNUM_W-1:0] snum;

    always_comb begin
        n_mx = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue > n_mx)  n_mx = i_blue;
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn)  n_mn = i_blue;
        // ties: green over blue and red, blue over red
        if (i_green >= i_red && i_green >= i_blue) begin
            n_base = HB_120;
        end else if (i_blue >= i_green && i_blue >= i_red) begin
            n_base = HB_240;
        end else if (i_green >= i_blue) begin
            n_base = HB_0;
        end else begin
            n_base = HB_360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
        if (i_en) begin
            r_s1_r    <= i_red;
            r_s1_g    <= i_green;
            r_s1_b    <= i_blue;
            r_s1_mx   <= n_mx;
            r_s1_mn   <= n_mn;
            r_s1_base <= n_base;
        end
    end

    always_comb begin
        chroma = r_s1_mx - r_s1_mn;
        case (r_s1_base)
            HB_120: begin
                pos = r_s1_b;
                neg = r_s1_r;
            end
            HB_240: begin
                pos = r_s1_r;
                neg = r_s1_g;
            end
            default: begin
                pos = r_s1_g;
                neg = r_s1_b;
            end
        endcase
        // biased difference chroma + diff, always in 0 .. 2*chroma
        dp   = DP_W'(chroma) + DP_W'(pos) - DP_W'(neg);
        hnum = HNUM_W'(HUE_GAIN2) * HNUM_W'(dp) + HNUM_W'(chroma);
        snum = (SNUM_W'({chroma, 1'b0}) * SNUM_W'(COMP_MAX) + SNUM_W'(r_s1_mx))
               << SAT_SHIFT;

        n_slot.hue.rem  = hnum[HNUM_W-1:HUE_QW];
        n_slot.hue.bits = hnum[HUE_QW-1:0];
        n_slot.hue.dvs  = {chroma, 1'b0};
        n_slot.sat.rem  = snum[SNUM_W-1:HUE_QW];
        n_slot.sat.bits = snum[HUE_QW-1:0];
        n_slot.sat.dvs  = {r_s1_mx, 1'b0};
        n_slot.base     = r_s1_base;
        n_slot.grey     = (chroma == '0);
        n_slot.black    = (r_s1_mx == '0);
        n_slot.value    = r_s1_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (i_en) begin
            r_s2_slot <= n_slot;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_slot  = r_s2_slot;

endmodule

[rtl/rth_div_step.sv]
// rth_div_step: one pipeline stage of the two restoring dividers.
// Depends on rth_pkg.
module rth_div_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rth_pkg::t_div_slot i_slot,
    output logic               o_valid,
    output rth_pkg::t_div_slot o_slot
);
    import rth_pkg::*;

    logic      r_valid;
    t_div_slot r_slot;
    t_div_slot n_slot;

    always_comb begin
        n_slot     = i_slot;
        n_slot.hue = div_step(i_slot.hue);
        n_slot.sat = div_step(i_slot.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_slot <= n_slot;
        end
    end

    assign o_valid = r_valid;
    assign o_slot  = r_slot;

endmodule

[rtl/rth_back.sv]
// rth_back: adds the hue offset, wraps at 360 degrees, zeroes the special
// cases and holds the output register. Depends on rth_pkg.
module rth_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rth_pkg::t_div_slot i_slot,
    output logic               o_valid,
    output rth_pkg::t_hue      o_hue,
    output rth_pkg::t_comp     o_sat,
    output rth_pkg::t_comp     o_val
);
    import rth_pkg::*;

    logic                 r_valid;
    t_hue                 r_hue;
    t_comp                r_sat;
    t_comp                r_val;
    t_hue                 n_hue;
    t_comp                n_sat;
    logic [HUE_SUM_W-1:0] sum;

    always_comb begin
        sum = HUE_SUM_W'(i_slot.hue.bits) + hue_offset(i_slot.base);
        if (sum >= HUE_SUM_W'(HUE_FULL)) begin
            sum = sum - HUE_SUM_W'(HUE_FULL);
        end
        n_hue = i_slot.grey  ? '0 : sum[HUE_W-1:0];
        n_sat = i_slot.black ? '0 : i_slot.sat.bits[HUE_QW-1:SAT_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= i_slot.value;
        end
    end

    assign o_valid = r_valid;
    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_val   = r_val;

endmodule

[rtl/rgb_to_hsv_converter.sv]
// rgb_to_hsv_converter: top level of the pipelined RGB to HSV converter.
// Depends on rth_pkg, rth_ifs, rth_front, rth_div_step and rth_back.
//
//   port     | dir | fields                          | transfer
//   ---------+-----+---------------------------------+-------------------
//   i_pix    | in  | red, green, blue                | valid && ready
//   o_hsv    | out | hue, saturation, brightness     | valid && ready
//
// Two front stages, then one quotient bit per stage in the hue and saturation
// dividers, then one output register. One pixel per clock in and out while
// the output is not stalled; synchronous active-low reset clears only
// the valid bits. An output stall freezes every stage on one shared enable,
// so nothing drops or repeats; i_pix.ready is high while the output
// register is empty or being taken.
module rgb_to_hsv_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rth_pix_if.sink       i_pix,
    rth_hsv_if.source     o_hsv
);
    import rth_pkg::*;

    logic      w_en;
    logic      w_valid [0:DIV_STEPS];
    t_div_slot w_slot  [0:DIV_STEPS];
    logic      w_out_valid;

    // Pipeline moves whenever the output register is free or draining
    assign w_en        = !w_out_valid || o_hsv.ready;
    assign i_pix.ready = w_en;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pix.valid),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (w_valid[0]),
        .o_slot  (w_slot[0])
    );

    // Division chain: hue fraction and saturation, one bit per stage
    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_div
        rth_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[gi]),
            .i_slot  (w_slot[gi]),
            .o_valid (w_valid[gi+1]),
            .o_slot  (w_slot[gi+1])
        );
    end

    rth_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[DIV_STEPS]),
        .i_slot  (w_slot[DIV_STEPS]),
        .o_valid (w_out_valid),
        .o_hue   (o_hsv.hue),
        .o_sat   (o_hsv.saturation),
        .o_val   (o_hsv.brightness)
    );

    assign o_hsv.valid = w_out_valid;

endmodule

[rtl/rth_checker.sv]
// rth_checker: port-level assertions for rgb_to_hsv_converter and its bind.
// Depends on rth_pkg.
module rth_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input rth_pkg::t_hue  i_hue,
    input rth_pkg::t_comp i_sat,
    input rth_pkg::t_comp i_val
);
    import rth_pkg::*;

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hue)
            && $stable(i_sat) && $stable(i_val))
        else $error("stalled result changed");

    // Back pressure reaches the input
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while pipeline stalled");

    // Hue wrapped below 360 degrees
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_hue) < HUE_FULL))
        else $error("hue not wrapped");

    // Black pixel has no saturation
    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_val == '0) |-> (i_sat == '0))
        else $error("black pixel with saturation");

endmodule

bind rgb_to_hsv_converter rth_checker u_rth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsv.valid),
    .i_out_ready (o_hsv.ready),
    .i_hue       (o_hsv.hue),
    .i_sat       (o_hsv.saturation),
    .i_val       (o_hsv.brightness)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for rgb_to_hsv_converter, pixels in, HSV out.
// Depends on rth_pkg, rth_ifs and the converter RTL.
module testbench;
    import rth_pkg::*;

    // One pixel, one HSV result, and one row of the stimulus table.
    // A row with "known" set carries a hand-written result; otherwise the
    // result is filled in by the predictor when the pixel is transferred.
    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
    } t_pixel;

    typedef struct packed {
        t_hue  hue;
        t_comp saturation;
        t_comp brightness;
    } t_hsv;

    typedef struct packed {
        t_pixel pix;
        logic   known;
        t_hsv   hsv;
    } t_probe;

    // Pipeline depth as the top level states it: two front stages, one stage
    // per quotient bit, one output register.
    localparam int PIPE_DEPTH     = 2 + DIV_STEPS + 1;
    localparam int NUM_PROBES     = 25;
    localparam int RAND_PER_PHASE = 133;
    localparam int NUM_PHASES     = 4;
    localparam int REPORT_MAX     = 10;
    // Roughly 560 pixels; even with both sides idling this is far above the
    // slowest legal run.
    localparam int CYCLE_LIMIT    = 200000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rth_pix_if pix_ch ();
    rth_hsv_if hsv_ch ();

    rgb_to_hsv_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_hsv   (hsv_ch)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle and stall rates in percent, changed per phase by the stimulus.
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;

    // Pixels transferred in, oldest first, each with the HSV it must produce.
    t_probe hsv_pending [$];

    // Directed pixels: black, white, greys, pure primaries and secondaries,
    // single-LSB colors, ties for the largest component (green beats blue
    // and red, blue beats red), chroma of one, and the red-largest sextant
    // with blue above green. Hues of the obvious rows are written out in
    // 1/64 degree units (120 deg = 7680, 240 deg = 15360, ...).
    t_probe probe_table [NUM_PROBES] = '{
        '{'{8'd0,   8'd0,   8'd0  }, 1'b1, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{15'd0,     8'd0,   8'd255}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{15'd0,     8'd0,   8'd128}},
        '{'{8'd1,   8'd1,   8'd1  }, 1'b1, '{15'd0,     8'd0,   8'd1  }},
        '{'{8'd255, 8'd0,   8'd0  }, 1'b1, '{15'd0,     8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd0  }, 1'b1, '{15'd7680,  8'd255, 8'd255}},
        '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{15'd15360, 8'd255, 8'd255}},
        '{'{8'd255, 8'd255, 8'd0  }, 1'b1, '{15'd3840,  8'd255, 8'd255}},
        '{'{8'd0,   8'd255, 8'd255}, 1'b1, '{15'd11520, 8'd255, 8'd255}},
        '{'{8'd255, 8'd0,   8'd255}, 1'b1, '{15'd19200, 8'd255, 8'd255}},
        '{'{8'd1,   8'd0,   8'd0  }, 1'b1, '{15'd0,     8'd255, 8'd1  }},
        '{'{8'd0,   8'd1,   8'd0  }, 1'b1, '{15'd7680,  8'd255, 8'd1  }},
        '{'{8'd0,   8'd0,   8'd1  }, 1'b1, '{15'd15360, 8'd255, 8'd1  }},
        '{'{8'd254, 8'd255, 8'd255}, 1'b1, '{15'd11520, 8'd1,   8'd255}},
        '{'{8'd255, 8'd254, 8'd254}, 1'b1, '{15'd0,     8'd1,   8'd255}},
        '{'{8'd255, 8'd0,   8'd1  }, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd255, 8'd1,   8'd0  }, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd128, 8'd255, 8'd128}, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd100, 8'd50,  8'd200}, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd200, 8'd100, 8'd150}, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd170, 8'd85,  8'd0  }, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd0,   8'd128, 8'd255}, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd255, 8'd128, 8'd0  }, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd2,   8'd1,   8'd0  }, 1'b0, '{15'd0,     8'd0,   8'd0  }},
        '{'{8'd85,  8'd170, 8'd255}, 1'b0, '{15'd0,     8'd0,   8'd0  }}
    };

    // HSV of one pixel. Sextant priority: green if it ties for the top,
    // then blue, then red; red splits into the 0 and 360 degree offsets
    // depending on whether green or blue is larger. Hue is rounded half up
    // in 1/64 degree units and wrapped at 360 degrees.
    function automatic t_hsv hsv_of_pixel(input t_pixel px);
        int        r, g, b;
        int        top, bottom, chroma, diff, num, hue;
        t_hue_base sextant;
        t_hsv      res;
        r      = px.red;
        g      = px.green;
        b      = px.blue;
        top    = (r > g) ? r : g;
        top    = (b > top) ? b : top;
        bottom = (r < g) ? r : g;
        bottom = (b < bottom) ? b : bottom;
        chroma = top - bottom;

        if (g >= r && g >= b) begin
            sextant = HB_120;
            diff    = b - r;
        end else if (b >= g && b >= r) begin
            sextant = HB_240;
            diff    = r - g;
        end else if (g >= b) begin
            sextant = HB_0;
            diff    = g - b;
        end else begin
            sextant = HB_360;
            diff    = g - b;
        end

        hue = 0;
        if (chroma != 0) begin
            case (sextant)
                HB_0:    num = 0;
                HB_120:  num = DEG120;
                HB_240:  num = DEG240;
                default: num = DEG360;
            endcase
            num = num * HUE_FRAC * chroma + DEG60 * HUE_FRAC * diff;
            if (num < 0) num = 0;
            hue = (2 * num + chroma) / (2 * chroma);
            while (hue >= HUE_FULL) hue -= HUE_FULL;
        end

        res.hue        = t_hue'(hue);
        res.saturation = (top == 0) ? '0 : t_comp'((2 * chroma * COMP_MAX + top) / (2 * top));
        res.brightness = t_comp'(top);
        return res;
    endfunction

    // Random pixel, biased toward the corners of the color space: greys,
    // ties for the top, chroma of one, saturated extremes, tiny values and
    // the red-top / blue-over-green sextant. The rest is uniform.
    function automatic t_pixel random_pixel();
        t_pixel px;
        int     top, mid;
        px.red   = t_comp'($urandom);
        px.green = t_comp'($urandom);
        px.blue  = t_comp'($urandom);
        case ($urandom_range(0, 9))
            4: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            5: begin
                top = $urandom_range(1, COMP_MAX);
                px.red   = t_comp'(top);
                px.green = t_comp'(top);
                px.blue  = t_comp'(top);
                case ($urandom_range(0, 2))
                    0:       px.red   = t_comp'($urandom_range(0, top));
                    1:       px.green = t_comp'($urandom_range(0, top));
                    default: px.blue  = t_comp'($urandom_range(0, top));
                endcase
            end
            6: begin
                px.green = px.red ^ t_comp'($urandom_range(0, 1));
                px.blue  = px.red ^ t_comp'($urandom_range(0, 1));
            end
            7: begin
                px.red   = ($urandom_range(0, 2) == 0) ? '0 : t_comp'(COMP_MAX);
                px.green = ($urandom_range(0, 2) == 0) ? '0 : t_comp'(COMP_MAX);
                px.blue  = ($urandom_range(0, 1) == 0) ? '0 : t_comp'(COMP_MAX);
            end
            8: begin
                px.red   = t_comp'($urandom_range(0, 3));
                px.green = t_comp'($urandom_range(0, 3));
                px.blue  = t_comp'($urandom_range(0, 3));
            end
            9: begin
                top = $urandom_range(2, COMP_MAX);
                mid = $urandom_range(1, top - 1);
                px.red   = t_comp'(top);
                px.blue  = t_comp'(mid);
                px.green = t_comp'($urandom_range(0, mid - 1));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Drive one pixel starting at a falling edge: optional idle cycles, then
    // hold valid until a rising edge sees ready. The expected HSV is queued
    // at the edge where the transfer happens. Returns at the next falling
    // edge with valid still high, so back-to-back pixels never drop it.
    task automatic send_pixel(input t_probe p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid = 1'b1;
        pix_ch.red   = p.pix.red;
        pix_ch.green = p.pix.green;
        pix_ch.blue  = p.pix.blue;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        if (!p.known) p.hsv = hsv_of_pixel(p.pix);
        hsv_pending.push_back(p);
        @(negedge i_clk);
    endtask

    // Receiver: ready is re-rolled at every falling edge.
    always @(negedge i_clk) begin
        hsv_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Result checker: every output transfer is matched against the oldest
    // queued pixel. Sampling at the rising edge reads the values from before
    // the edge, since the converter's registers update after this runs.
    always @(posedge i_clk) begin : check_results
        t_probe want;
        t_hsv   got;
        if (i_rst_n && hsv_ch.valid && hsv_ch.ready) begin
            got.hue        = hsv_ch.hue;
            got.saturation = hsv_ch.saturation;
            got.brightness = hsv_ch.brightness;
            if (hsv_pending.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result: hue=%0d sat=%0d val=%0d",
                             got.hue, got.saturation, got.brightness);
                mismatch_count++;
            end else begin
                want = hsv_pending.pop_front();
                if (got.hue !== want.hsv.hue ||
                    got.saturation !== want.hsv.saturation ||
                    got.brightness !== want.hsv.brightness) begin
                    if (mismatch_count < REPORT_MAX)
                        $display({"mismatch rgb=(%0d,%0d,%0d): ",
                                  "expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d"},
                                 want.pix.red, want.pix.green, want.pix.blue,
                                 want.hsv.hue, want.hsv.saturation,
                                 want.hsv.brightness,
                                 got.hue, got.saturation, got.brightness);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop if the pipeline hangs.
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus: reset, the directed table with no idling, then random
    // pixels in four phases (no idling, sender idle, receiver stalls, both).
    initial begin : stimulus
        t_probe p;
        int     phase;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (probe_table[i]) send_pixel(probe_table[i]);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            repeat (RAND_PER_PHASE) begin
                p.pix   = random_pixel();
                p.known = 1'b0;
                p.hsv   = '0;
                send_pixel(p);
            end
        end
        pix_ch.valid = 1'b0;

        // Drain, then give the pipeline time to show any stray result.
        while (hsv_pending.size() != 0) @(posedge i_clk);
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
